// ===== hdl/msfs_pkg.sv =====
// shared constants, types and command codes for the spin flip sampler
// no dependencies; imported by every module of the block
package msfs_pkg;

  localparam int MAX_SITES = 16;
  localparam int CFG_W     = MAX_SITES;
  localparam int ADDR_W    = 16;
  localparam int AMP_W     = 18;
  localparam int ENTRY_W   = 2 * AMP_W;
  localparam int PROB_W    = 36;
  localparam int DRAW_W    = 16;
  localparam int THR_W     = PROB_W + DRAW_W;
  localparam int SITE_W    = 4;
  localparam int NS_W      = 5;
  localparam int CMD_W     = 2;
  localparam int IN_DATA_W = 88;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 2;

  localparam int APB_AW = 2;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] REG_N_SITES_ADDR = 2'd0;
  localparam logic [NS_W-1:0]   N_SITES_RESET    = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_AMP = 2'd0,
    CMD_SET_CFG   = 2'd1,
    CMD_RECOMPUTE = 2'd2,
    CMD_FLIP      = 2'd3
  } cmd_t;

  // controller to datapath strobes
  typedef struct packed {
    logic capture;
    logic multiply;
    logic commit;
  } ctl_cmd_t;

endpackage

// ===== hdl/msfs_ctrl.sv =====
// item sequencer for the spin flip sampler: accept, multiply, commit
// depends on msfs_pkg; drives the datapath through ctl_cmd_t
module msfs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output msfs_pkg::ctl_cmd_t ctl
);
  import msfs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ctl           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ctl.capture = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        ctl.multiply = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          ctl.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/msfs_datapath.sv =====
// amplitude table, squaring, metropolis test and held state
// depends on msfs_pkg; sequenced by msfs_ctrl
module msfs_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  msfs_pkg::ctl_cmd_t             ctl,
  input  logic [msfs_pkg::NS_W-1:0]      n_sites,
  input  logic [msfs_pkg::CMD_W-1:0]     command,
  input  logic [msfs_pkg::ADDR_W-1:0]    table_address,
  input  logic signed [msfs_pkg::AMP_W-1:0] amplitude_real,
  input  logic signed [msfs_pkg::AMP_W-1:0] amplitude_imag,
  input  logic [msfs_pkg::CFG_W-1:0]     new_configuration,
  input  logic [msfs_pkg::SITE_W-1:0]    flip_site,
  input  logic [msfs_pkg::DRAW_W-1:0]    uniform_draw,
  output logic                           accepted,
  output logic                           site_error,
  output logic [msfs_pkg::CFG_W-1:0]     current_configuration,
  output logic [msfs_pkg::PROB_W-1:0]    current_probability
);
  import msfs_pkg::*;

  logic [ENTRY_W-1:0] amp_mem [2**MAX_SITES];

  logic [NS_W-1:0]    n_eff;
  logic [CFG_W-1:0]   site_mask;
  logic [SITE_W-1:0]  bit_pos;
  logic [CFG_W-1:0]   flip_bit;
  logic [CFG_W-1:0]   cand_in;
  logic               err_in;

  cmd_t               cmd_r;
  logic [CFG_W-1:0]   cand_r;
  logic               err_r;
  logic [DRAW_W-1:0]  draw_r;
  logic [ENTRY_W-1:0] rd_data_r;

  logic signed [AMP_W-1:0]   rd_re, rd_im;
  logic signed [2*AMP_W-1:0] prod_re, prod_im;
  logic [PROB_W-1:0]  sq_re_r, sq_im_r;
  logic [THR_W-1:0]   thr_r;

  logic [PROB_W-1:0]  cand_prob;
  logic               pass;
  logic [CFG_W-1:0]   spin_r, spin_nxt;
  logic [PROB_W-1:0]  held_r, held_nxt;
  logic               acc_r, acc_nxt;
  logic               err_out_r;

  assign n_eff = (n_sites == '0) ? NS_W'(1) :
                 (n_sites > NS_W'(MAX_SITES)) ? NS_W'(MAX_SITES) : n_sites;
  assign site_mask = ~({CFG_W{1'b1}} << n_eff);
  assign bit_pos   = SITE_W'(n_eff - NS_W'(1) - NS_W'(flip_site));
  assign flip_bit  = CFG_W'(1) << bit_pos;
  assign err_in    = (cmd_t'(command) == CMD_FLIP) && (NS_W'(flip_site) >= n_eff);

  always_comb begin
    case (cmd_t'(command))
      CMD_SET_CFG: cand_in = new_configuration & site_mask;
      CMD_FLIP:    cand_in = spin_r ^ flip_bit;
      default:     cand_in = spin_r;
    endcase
  end

  // table port: write on a write item; every item also reads the candidate entry
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      if (cmd_t'(command) == CMD_WRITE_AMP) begin
        amp_mem[table_address[MAX_SITES-1:0]] <= {amplitude_imag, amplitude_real};
      end
      rd_data_r <= amp_mem[cand_in[MAX_SITES-1:0] & site_mask[MAX_SITES-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= cmd_t'(command);
      cand_r <= cand_in;
      err_r  <= err_in;
      draw_r <= uniform_draw;
    end
  end

  assign rd_re   = rd_data_r[AMP_W-1:0];
  assign rd_im   = rd_data_r[ENTRY_W-1:AMP_W];
  assign prod_re = rd_re * rd_re;
  assign prod_im = rd_im * rd_im;

  always_ff @(posedge clk) begin
    if (ctl.multiply) begin
      sq_re_r <= $unsigned(prod_re);
      sq_im_r <= $unsigned(prod_im);
      thr_r   <= draw_r * held_r;
    end
  end

  assign cand_prob = sq_re_r + sq_im_r;
  assign pass      = {cand_prob, {DRAW_W{1'b0}}} > thr_r;

  always_comb begin
    spin_nxt = spin_r;
    held_nxt = held_r;
    acc_nxt  = 1'b0;
    case (cmd_r)
      CMD_SET_CFG: begin
        spin_nxt = cand_r;
        held_nxt = cand_prob;
      end
      CMD_RECOMPUTE: held_nxt = cand_prob;
      CMD_FLIP: begin
        if (!err_r && pass) begin
          spin_nxt = cand_r;
          held_nxt = cand_prob;
          acc_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_r    <= '0;
      held_r    <= '0;
      acc_r     <= 1'b0;
      err_out_r <= 1'b0;
    end else if (ctl.commit) begin
      spin_r    <= spin_nxt;
      held_r    <= held_nxt;
      acc_r     <= acc_nxt;
      err_out_r <= err_r;
    end
  end

  assign accepted              = acc_r;
  assign site_error            = err_out_r;
  assign current_configuration = spin_r;
  assign current_probability   = held_r;

endmodule

// ===== hdl/metropolis_spin_flip_sampler_core.sv =====
// top level of the metropolis spin flip sampler: stream ports, apb register
// depends on msfs_pkg, msfs_ctrl and msfs_datapath
//
// Each item passes through ST_IDLE, ST_MUL and ST_FIN. The edge that accepts
// the item also reads the amplitude table (registered memory port); the next
// cycle does the two 18x18 squarings and the draw times held-probability
// product, and ST_FIN the sum, the acceptance compare and the state update,
// done once the result side is free. in_tready stays low from the accepting
// edge until that update, so no new item is taken before the last is done; a
// result that waits on out_tready holds back the update of the next item. The
// amplitude table has no reset; entries read before being written return
// arbitrary data. The user must write n_sites through the apb port at address
// 0 only while the block is idle; the block itself does not enforce this.
module metropolis_spin_flip_sampler_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // table_address, amplitude_real, amplitude_imag, new_configuration,
  // flip_site, uniform_draw
  input  logic [msfs_pkg::IN_DATA_W-1:0]       in_tdata,
  // command
  input  logic [msfs_pkg::CMD_W-1:0]           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // current_configuration, current_probability, 4 bits zero
  output logic [msfs_pkg::OUT_DATA_W-1:0]      out_tdata,
  // accepted, site_error
  output logic [msfs_pkg::OUT_USER_W-1:0]      out_tuser,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [msfs_pkg::APB_AW-1:0]          cfg_paddr,
  input  logic [msfs_pkg::APB_DW-1:0]          cfg_pwdata,
  output logic [msfs_pkg::APB_DW-1:0]          cfg_prdata,
  output logic                                 cfg_pready
);
  import msfs_pkg::*;

  ctl_cmd_t          ctl;
  logic [NS_W-1:0]   n_sites_r;
  logic              cfg_wr;
  logic              accepted, site_error;
  logic [CFG_W-1:0]  current_configuration;
  logic [PROB_W-1:0] current_probability;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_sites_r <= N_SITES_RESET;
    end else if (cfg_wr && cfg_paddr == REG_N_SITES_ADDR) begin
      n_sites_r <= cfg_pwdata[NS_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      REG_N_SITES_ADDR: cfg_prdata = {{(APB_DW-NS_W){1'b0}}, n_sites_r};
      default:          cfg_prdata = '0;
    endcase
  end

  msfs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  msfs_datapath u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ctl                   (ctl),
    .n_sites               (n_sites_r),
    .command               (in_tuser),
    .table_address         (in_tdata[15:0]),
    .amplitude_real        (in_tdata[33:16]),
    .amplitude_imag        (in_tdata[51:34]),
    .new_configuration     (in_tdata[67:52]),
    .flip_site             (in_tdata[71:68]),
    .uniform_draw          (in_tdata[87:72]),
    .accepted              (accepted),
    .site_error            (site_error),
    .current_configuration (current_configuration),
    .current_probability   (current_probability)
  );

  assign out_tdata = {{(OUT_DATA_W-CFG_W-PROB_W){1'b0}}, current_probability,
                      current_configuration};
  assign out_tuser = {site_error, accepted};

  a_err_not_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("flip both accepted and flagged as bad site");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready ##1 !in_tready)
    else $error("item taken while another is being processed");

  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[51:16] <= 36'h800000000))
    else $error("held probability above full scale");

  a_acc_changes_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) ##1 (out_tvalid && out_tuser[0]) |->
      $countones(out_tdata[15:0] ^ $past(out_tdata[15:0])) == 1)
    else $error("accepted flip did not invert exactly one site");

endmodule
